>>> sv/assert_macros.svh
// assertion macros shared by the ja3 string builder rtl
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define JAS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jas assertion failed");
// condition must never be true outside reset
`define JAS_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("jas forbidden condition seen");
`else
`define JAS_ASSERT(label, clk, rst, prop)
`define JAS_NEVER(label, clk, rst, cond)
`endif
`endif

>>> sv/jas_pkg.sv
// shared types and constants of the ja3 string builder
// no dependencies
`default_nettype none

package jas_pkg;

   // section codes
   localparam logic [2:0] SEC_VERSION   = 3'd0;
   localparam logic [2:0] SEC_CIPHER    = 3'd1;
   localparam logic [2:0] SEC_EXTENSION = 3'd2;
   localparam logic [2:0] SEC_GROUP     = 3'd3;
   localparam logic [2:0] SEC_POINT     = 3'd4;

   // ascii codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // grease detection
   localparam logic [15:0] GREASE_MASK    = 16'h0f0f;
   localparam logic [15:0] GREASE_PATTERN = 16'h0a0a;

   // digit positions, most significant first
   localparam logic [2:0] DIGIT_LAST = 3'd4;

   // one unit of work for the back end
   typedef struct packed {
      logic [2:0]  pre_commas;   // commas for sections passed over
      logic        dash;         // separator before the value
      logic        emit;         // write the value in decimal
      logic [15:0] value;
      logic [2:0]  first_digit;  // position of the leading nonzero digit
      logic [2:0]  post_commas;  // closing commas on the last item
      logic        term;         // terminator follows
      logic [15:0] grease;       // first grease cipher, for the terminator
   } cmd_type;

   function automatic logic [13:0] dec_weight(input logic [2:0] idx);
      logic [13:0] w;
      case (idx)
         3'd0:    w = 14'd10000;
         3'd1:    w = 14'd1000;
         3'd2:    w = 14'd100;
         3'd3:    w = 14'd10;
         default: w = 14'd1;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> sv/jas_front.sv
// front end: accepts items, tracks sections and grease, builds commands
// depends on jas_pkg
`default_nettype none

module jas_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [2:0]       req_func,
   input  wire logic [15:0]      req_value,
   input  wire logic             req_last,
   input  wire logic             q_full,
   output logic                  q_push,
   output jas_pkg::cmd_type      q_cmd
);

   logic [2:0]  cur_ff, cur_in;
   logic        has_ff, has_in;
   logic [15:0] grease_ff, grease_in;

   logic [2:0]  sec_raw, sec, pre;
   logic        has_cur, is_grease, grease_sec, drop, emit, accept;
   logic [15:0] grease_nxt;
   logic [2:0]  first_digit;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      sec_raw = (req_func < cur_ff) ? cur_ff : req_func;
      sec     = (sec_raw > jas_pkg::SEC_POINT) ? jas_pkg::SEC_POINT : sec_raw;
      pre     = sec - cur_ff;
      has_cur = (pre != 3'd0) ? 1'b0 : has_ff;

      is_grease  = ((req_value & jas_pkg::GREASE_MASK) == jas_pkg::GREASE_PATTERN)
                   && (req_value[7:0] == req_value[15:8]);
      grease_sec = sec inside {jas_pkg::SEC_CIPHER, jas_pkg::SEC_EXTENSION,
                               jas_pkg::SEC_GROUP};
      // version holds a single value
      drop = (grease_sec && is_grease) || ((sec == jas_pkg::SEC_VERSION) && has_cur);
      emit = !drop;

      grease_nxt = ((sec == jas_pkg::SEC_CIPHER) && is_grease && (grease_ff == 16'd0))
                   ? req_value : grease_ff;

      if (req_value >= 16'd10000)     first_digit = 3'd0;
      else if (req_value >= 16'd1000) first_digit = 3'd1;
      else if (req_value >= 16'd100)  first_digit = 3'd2;
      else if (req_value >= 16'd10)   first_digit = 3'd3;
      else                            first_digit = 3'd4;

      q_cmd.pre_commas  = pre;
      q_cmd.dash        = emit && has_cur;
      q_cmd.emit        = emit;
      q_cmd.value       = req_value;
      q_cmd.first_digit = first_digit;
      q_cmd.post_commas = req_last ? (jas_pkg::SEC_POINT - sec) : 3'd0;
      q_cmd.term        = req_last;
      q_cmd.grease      = grease_nxt;

      // items that produce no character never enter the queue
      q_push = accept && ((pre != 3'd0) || emit || req_last);

      cur_in    = cur_ff;
      has_in    = has_ff;
      grease_in = grease_ff;
      if (accept) begin
         if (req_last) begin
            cur_in    = jas_pkg::SEC_VERSION;
            has_in    = 1'b0;
            grease_in = 16'd0;
         end else begin
            cur_in    = sec;
            has_in    = has_cur || emit;
            grease_in = grease_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= jas_pkg::SEC_VERSION;
         has_ff    <= 1'b0;
         grease_ff <= 16'd0;
      end else begin
         cur_ff    <= cur_in;
         has_ff    <= has_in;
         grease_ff <= grease_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/jas_fifo.sv
// command queue between front and back end
// depends on jas_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module jas_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire jas_pkg::cmd_type  push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output jas_pkg::cmd_type       pop_cmd,
   output logic                   empty
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrMax   = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntDepth = CntWidth'(DEPTH);

   jas_pkg::cmd_type      mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full    = (count_ff == CntDepth);
   assign empty   = (count_ff == '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrMax) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrMax) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `JAS_NEVER(a_no_overflow, clock, reset, push && full)
   `JAS_NEVER(a_no_underflow, clock, reset, pop && empty)
   `JAS_ASSERT(a_count_bound, clock, reset, count_ff <= CntDepth)

endmodule

`default_nettype wire

>>> sv/jas_back.sv
// back end: turns commands into characters, one per cycle unless rsp stalls, into an output register
// depends on jas_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module jas_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire jas_pkg::cmd_type  q_cmd,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_character,
   output logic                   rsp_end_of_string,
   output logic [15:0]            rsp_first_grease
);

   // working copy of the command in progress
   logic [2:0]  pre_ff, pre_in;
   logic        dash_ff, dash_in;
   logic        emit_ff, emit_in;
   logic [15:0] rem_ff, rem_in;
   logic [2:0]  idx_ff, idx_in;
   logic [2:0]  post_ff, post_in;
   logic        term_ff, term_in;
   logic [15:0] grease_ff, grease_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_end_ff, rsp_end_in;
   logic [15:0] rsp_grease_ff, rsp_grease_in;

   logic        busy, out_adv, step, busy_after;
   logic [13:0] weight;
   logic [16:0] thr [1:9];
   logic [9:1]  ge;
   logic [3:0]  digit;
   logic [16:0] sub;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_character     = rsp_char_ff;
   assign rsp_end_of_string = rsp_end_ff;
   assign rsp_first_grease  = rsp_grease_ff;

   always_comb begin
      busy    = (pre_ff != 3'd0) || dash_ff || emit_ff || (post_ff != 3'd0) || term_ff;
      out_adv = !rsp_valid_ff || rsp_ready;
      step    = busy && out_adv;

      // one decimal digit per cycle while the output advances, by compare against the multiples of the weight
      weight = jas_pkg::dec_weight(idx_ff);
      digit  = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         thr[k] = 17'(k) * {3'b000, weight};
         ge[k]  = {1'b0, rem_ff} >= thr[k];
      end
      for (int k = 1; k <= 9; k++) begin
         digit = digit + {3'b000, ge[k]};
      end
      sub = 17'd0;
      for (int k = 1; k <= 9; k++) begin
         if (digit == 4'(k)) begin
            sub = thr[k];
         end
      end

      pre_in        = pre_ff;
      dash_in       = dash_ff;
      emit_in       = emit_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      post_in       = post_ff;
      term_in       = term_ff;
      grease_in     = grease_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_grease_in = rsp_grease_ff;
      rsp_valid_in  = step ? 1'b1 : (out_adv ? 1'b0 : rsp_valid_ff);

      if (step) begin
         rsp_end_in    = 1'b0;
         rsp_grease_in = 16'd0;
         if (pre_ff != 3'd0) begin
            rsp_char_in = jas_pkg::CHAR_COMMA;
            pre_in      = pre_ff - 3'd1;
         end else if (dash_ff) begin
            rsp_char_in = jas_pkg::CHAR_DASH;
            dash_in     = 1'b0;
         end else if (emit_ff) begin
            rsp_char_in = jas_pkg::CHAR_ZERO + {4'b0000, digit};
            rem_in      = rem_ff - sub[15:0];
            if (idx_ff == jas_pkg::DIGIT_LAST) begin
               emit_in = 1'b0;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end else if (post_ff != 3'd0) begin
            rsp_char_in = jas_pkg::CHAR_COMMA;
            post_in     = post_ff - 3'd1;
         end else begin
            rsp_char_in   = jas_pkg::CHAR_NUL;
            rsp_end_in    = 1'b1;
            rsp_grease_in = grease_ff;
            term_in       = 1'b0;
         end
      end

      // next command loads as the current one hands out its final character
      busy_after = (pre_in != 3'd0) || dash_in || emit_in || (post_in != 3'd0) || term_in;
      q_pop      = !q_empty && !busy_after;
      if (q_pop) begin
         pre_in    = q_cmd.pre_commas;
         dash_in   = q_cmd.dash;
         emit_in   = q_cmd.emit;
         rem_in    = q_cmd.value;
         idx_in    = q_cmd.first_digit;
         post_in   = q_cmd.post_commas;
         term_in   = q_cmd.term;
         grease_in = q_cmd.grease;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff       <= 3'd0;
         dash_ff      <= 1'b0;
         emit_ff      <= 1'b0;
         post_ff      <= 3'd0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pre_ff       <= pre_in;
         dash_ff      <= dash_in;
         emit_ff      <= emit_in;
         post_ff      <= post_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      idx_ff        <= idx_in;
      grease_ff     <= grease_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_grease_ff <= rsp_grease_in;
   end

   `JAS_ASSERT(a_term_is_nul, clock, reset,
      (rsp_valid_ff && rsp_end_ff) |-> (rsp_char_ff == jas_pkg::CHAR_NUL))
   `JAS_ASSERT(a_grease_only_at_end, clock, reset,
      (rsp_valid_ff && !rsp_end_ff) |-> (rsp_grease_ff == 16'd0))
   `JAS_ASSERT(a_no_back_to_back_term, clock, reset,
      (rsp_valid_ff && rsp_end_ff && rsp_ready) |=> !(rsp_valid_ff && rsp_end_ff))

endmodule

`default_nettype wire

>>> sv/tls_ja3_string_builder.sv
// top level of the ja3 client fingerprint string builder
// depends on jas_pkg, jas_front, jas_fifo and jas_back
`default_nettype none

// usage
// - req channel: one clienthello value per transaction, tagged with its section
//   in req_func (version, cipher, extension, group, point format); req_last
//   marks the final value of the clienthello
// - rsp channel: the ja3 text, one ascii character per transaction; the string
//   ends with a nul character flagged by rsp_end_of_string, which also carries
//   the first grease cipher (zero if none)
// - the front end updates section and grease state at accept and hands a
//   command to a small queue; the back end writes it out one character a cycle
//   while rsp is not stalled; the first character of an item passes through
//   the queue, the back end working copy and the output register
// - an item yields 1 to 10 characters; items that yield nothing never enter
//   the queue
// - req_ready drops only when the command queue is full
// - a stall on rsp holds the output register, then fills the queue, then stops
//   accepts; nothing is lost
// - reset clears section state, the queue and the output register at once

module tls_ja3_string_builder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_func,
   input  wire logic [15:0] req_value,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_character,
   output logic             rsp_end_of_string,
   output logic [15:0]      rsp_first_grease
);

   // commands between front and back end
   jas_pkg::cmd_type push_cmd;
   jas_pkg::cmd_type pop_cmd;
   logic             q_push, q_pop, q_full, q_empty;

   // section tracking and grease filtering
   jas_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_value (req_value),
      .req_last  (req_last),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   // decouples accepts from character output
   jas_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   // character serializer with registered output
   jas_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_cmd             (pop_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_character     (rsp_character),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_first_grease  (rsp_first_grease)
   );

endmodule

`default_nettype wire

>>> tb/ja3_text_checker.sv
// checker for the ja3 string builder: watches both channels, predicts the ja3 text
// of every accepted value and compares each character as it leaves the block
// depends on jas_pkg

module ja3_text_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_value,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_character,
   input  logic        rsp_end_of_string,
   input  logic [15:0] rsp_first_grease,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [7:0]  character;
      logic        end_of_string;
      logic [15:0] first_grease;
   } ja3_char_type;

   ja3_char_type ja3_chars_due [$];
   logic [2:0]   cur_section;
   logic         has_value;
   logic [15:0]  first_grease;

   function automatic void push_char(input logic [7:0] ch, input logic eos,
                                     input logic [15:0] grease);
      ja3_char_type c;
      c.character     = ch;
      c.end_of_string = eos;
      c.first_grease  = grease;
      ja3_chars_due.push_back(c);
   endfunction

   // text that one clienthello value adds, with section and grease bookkeeping
   task automatic append_ja3_text(input logic [2:0] func, input logic [15:0] value,
                                  input logic last);
      logic [2:0] target;
      logic       drop;
      logic [7:0] digits [5];
      int         n;
      int         rest;
      int         i;
      target = (func < cur_section) ? cur_section : func;
      if (target > jas_pkg::SEC_POINT)
         target = jas_pkg::SEC_POINT;
      while (cur_section < target) begin
         push_char(jas_pkg::CHAR_COMMA, 1'b0, 16'h0000);
         cur_section++;
         has_value = 1'b0;
      end
      drop = 1'b0;
      if (target >= jas_pkg::SEC_CIPHER && target <= jas_pkg::SEC_GROUP &&
          (value & jas_pkg::GREASE_MASK) == jas_pkg::GREASE_PATTERN &&
          value[15:8] == value[7:0]) begin
         drop = 1'b1;
         if (target == jas_pkg::SEC_CIPHER && first_grease == 16'h0000)
            first_grease = value;
      end
      if (target == jas_pkg::SEC_VERSION && has_value)
         drop = 1'b1;
      if (!drop) begin
         if (has_value)
            push_char(jas_pkg::CHAR_DASH, 1'b0, 16'h0000);
         rest = value;
         n = 0;
         do begin
            digits[n] = jas_pkg::CHAR_ZERO + 8'(rest % 10);
            rest = rest / 10;
            n++;
         end while (rest != 0);
         for (i = n - 1; i >= 0; i--)
            push_char(digits[i], 1'b0, 16'h0000);
         has_value = 1'b1;
      end
      if (last) begin
         while (cur_section < jas_pkg::SEC_POINT) begin
            push_char(jas_pkg::CHAR_COMMA, 1'b0, 16'h0000);
            cur_section++;
         end
         push_char(jas_pkg::CHAR_NUL, 1'b1, first_grease);
         cur_section  = jas_pkg::SEC_VERSION;
         has_value    = 1'b0;
         first_grease = 16'h0000;
      end
   endtask

   always @(posedge clock) begin
      ja3_char_type want;
      if (reset) begin
         ja3_chars_due.delete();
         cur_section  = jas_pkg::SEC_VERSION;
         has_value    = 1'b0;
         first_grease = 16'h0000;
         fail_count   = 0;
      end else begin
         // outgoing character first: it can never stem from this edge's accept
         if (rsp_valid && rsp_ready) begin
            if (ja3_chars_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected character %h eos %b grease %h",
                           rsp_character, rsp_end_of_string, rsp_first_grease);
            end else begin
               want = ja3_chars_due.pop_front();
               if (rsp_character !== want.character ||
                   rsp_end_of_string !== want.end_of_string ||
                   rsp_first_grease !== want.first_grease) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("char mismatch: expected %h/%b/%h, got %h/%b/%h",
                              want.character, want.end_of_string, want.first_grease,
                              rsp_character, rsp_end_of_string, rsp_first_grease);
               end
            end
         end
         if (req_valid && req_ready)
            append_ja3_text(req_func, req_value, req_last);
      end
      pending = ja3_chars_due.size();
   end

endmodule

>>> tb/tls_ja3_string_builder_test.sv
// top of the ja3 string builder testbench: clock, reset, stimulus and verdict
// depends on jas_pkg, ja3_text_checker and the tls_ja3_string_builder rtl

module tls_ja3_string_builder_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 180;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] value;
      logic        last;
   } hello_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = jas_pkg::SEC_VERSION;
   logic [15:0] req_value = 16'h0000;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_character;
   logic        rsp_end_of_string;
   logic [15:0] rsp_first_grease;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;   // chance per cycle that the sender holds back
   int recv_stall_pct = 0;  // chance per cycle that the receiver stalls

   always #10 clock = ~clock;

   tls_ja3_string_builder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_value         (req_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_character     (rsp_character),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_first_grease  (rsp_first_grease)
   );

   ja3_text_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_value         (req_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_character     (rsp_character),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_first_grease  (rsp_first_grease),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // receiver: one ready decision per edge, stall rate set by the current phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      cycle_count <= cycle_count + 1;
   end

   // watchdog: a hung block or a lost character ends here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tls_ja3_string_builder_test failed");
      $finish;
   end

   // value spread: full range, shifted down toward short decimals, tiny ones
   function automatic logic [15:0] random_value();
      logic [15:0] v;
      v = 16'($urandom);
      case ($urandom_range(3))
         0:       v = v >> $urandom_range(15);
         1:       v = 16'($urandom_range(12));
         default: ;
      endcase
      return v;
   endfunction

   // grease: both bytes equal, low nibble of each is 0xa
   function automatic logic [15:0] grease_value();
      logic [7:0] b;
      b = {4'($urandom_range(15)), 4'ha};
      return {b, b};
   endfunction

   // one transaction on req; random hold-off before it per the phase
   task automatic send_item(input logic [2:0] func, input logic [15:0] value,
                            input logic last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 60)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // sender goes quiet until every predicted character has come out
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // mostly well-formed clienthellos with random content, some noise sequences
   task automatic send_hello();
      hello_item_type items [$];
      hello_item_type it;
      int             count;
      int             i;
      logic [2:0]     sec;
      if ($urandom_range(5) == 0) begin
         // noise: any section code, stray lasts in the middle
         count = $urandom_range(1, 8);
         for (i = 0; i < count; i++) begin
            it.func  = 3'($urandom_range(7));
            it.value = ($urandom_range(3) == 0) ? grease_value() : random_value();
            it.last  = ($urandom_range(7) == 0);
            items.push_back(it);
         end
      end else begin
         it.func  = jas_pkg::SEC_VERSION;
         it.value = random_value();
         it.last  = 1'b0;
         items.push_back(it);
         if ($urandom_range(7) == 0) begin
            it.value = random_value();
            items.push_back(it);
         end
         for (sec = jas_pkg::SEC_CIPHER; sec <= jas_pkg::SEC_POINT; sec++) begin
            count = $urandom_range(0, 4);
            for (i = 0; i < count; i++) begin
               it.func  = sec;
               it.value = (sec != jas_pkg::SEC_POINT && $urandom_range(3) == 0) ?
                          grease_value() : random_value();
               items.push_back(it);
            end
         end
      end
      items[items.size() - 1].last = 1'b1;
      foreach (items[k])
         send_item(items[k].func, items[k].value, items[k].last);
   endtask

   initial begin
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: a full hello with grease ciphers, a repeated version value,
      // going back a section, a skipped group section and an unknown code
      send_item(jas_pkg::SEC_VERSION,   16'd771,    1'b0);
      send_item(jas_pkg::SEC_VERSION,   16'd769,    1'b0);  // second version, dropped
      send_item(jas_pkg::SEC_CIPHER,    16'h0a0a,   1'b0);  // first grease cipher, kept aside
      send_item(jas_pkg::SEC_CIPHER,    16'd4865,   1'b0);
      send_item(jas_pkg::SEC_CIPHER,    16'hfafa,   1'b0);  // later grease, not remembered
      send_item(jas_pkg::SEC_CIPHER,    16'd0,      1'b0);
      send_item(jas_pkg::SEC_VERSION,   16'd5,      1'b0);  // lower code counts as cipher
      send_item(jas_pkg::SEC_EXTENSION, 16'd65535,  1'b0);
      send_item(jas_pkg::SEC_EXTENSION, 16'h1a1a,   1'b0);  // grease extension dropped
      send_item(jas_pkg::SEC_POINT,     16'd0,      1'b0);  // group section left empty
      send_item(jas_pkg::SEC_EXTENSION, 16'd10,     1'b0);
      send_item(3'd7,                   16'h2a2a,   1'b1);  // unknown code, grease kept
      // every cipher is grease, last while still in the cipher section
      send_item(jas_pkg::SEC_CIPHER,    16'hbaba,   1'b0);
      send_item(jas_pkg::SEC_CIPHER,    16'h3a3a,   1'b1);
      // grease in the version section is written out
      send_item(jas_pkg::SEC_VERSION,   16'h0a0a,   1'b1);
      // first item is the last one, all sections skipped
      send_item(jas_pkg::SEC_POINT,     16'd1,      1'b1);
      send_item(3'd5,                   16'hffff,   1'b0);
      send_item(3'd6,                   16'd9,      1'b0);
      send_item(jas_pkg::SEC_GROUP,     16'h7a7a,   1'b1);  // back into point format
      send_item(jas_pkg::SEC_EXTENSION, 16'h4a4a,   1'b1);  // only a dropped grease value
      send_item(jas_pkg::SEC_VERSION,   16'd10000,  1'b0);  // inner zeros
      send_item(jas_pkg::SEC_CIPHER,    16'd100,    1'b1);

      // random hellos over four idling phases; each phase starts drained
      for (phase = 0; phase < 4; phase++) begin
         drain_all();
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 86;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 86;
            end
            default: begin
               send_idle_pct = 14;
               recv_stall_pct = 14;
            end
         endcase
         while (items_sent < 22 + (phase + 1) * RANDOM_ITEMS / 4)
            send_hello();
      end

      // let the tail drain, then wait on for stray characters
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain_all();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tls_ja3_string_builder_test passed");
      else
         $display("tls_ja3_string_builder_test failed");
      $finish;
   end

endmodule
